// ===== src/vrot_pkg.sv =====
// ----------------------------------------------------------------------------
// vrot_pkg
// Shared constants and the arctangent table for the 2D degree rotator.
// ----------------------------------------------------------------------------
package vrot_pkg;

	// angle field and turn constants, 1/64 degree per unit
	localparam int ANGLE_W = 16;
	localparam logic signed [ANGLE_W-1:0] FULL_TURN    = 16'sd23040;
	localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 16'sd11520;
	localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd5760;

	// gain compensation 0.6072529350 with 24 fraction bits, kept positive
	localparam int GAIN_W = 25;
	localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 25'sd10188014;
	localparam int GAIN_SHIFT = 8;

	// guard bits below Q8.8 in the datapath
	localparam int GUARD_BITS = 16;

	// angle accumulator, 2^-22 degree per unit
	localparam int Z_W = 32;
	localparam int ATAN_TAB_SIZE = 24;
	localparam int ATAN_IDX_W = 5;

	// defaults for the top level parameters
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DEF_COMPONENT_WIDTH = 16;

	// atan(2^-i) in accumulator units, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [Z_W-1:0] val;
		case (idx)
			5'd0:    val = 32'sd188743680;
			5'd1:    val = 32'sd111421900;
			5'd2:    val = 32'sd58872272;
			5'd3:    val = 32'sd29884485;
			5'd4:    val = 32'sd15000234;
			5'd5:    val = 32'sd7507429;
			5'd6:    val = 32'sd3754631;
			5'd7:    val = 32'sd1877430;
			5'd8:    val = 32'sd938729;
			5'd9:    val = 32'sd469366;
			5'd10:   val = 32'sd234683;
			5'd11:   val = 32'sd117342;
			5'd12:   val = 32'sd58671;
			5'd13:   val = 32'sd29335;
			5'd14:   val = 32'sd14668;
			5'd15:   val = 32'sd7334;
			5'd16:   val = 32'sd3667;
			5'd17:   val = 32'sd1833;
			5'd18:   val = 32'sd917;
			5'd19:   val = 32'sd458;
			5'd20:   val = 32'sd229;
			5'd21:   val = 32'sd115;
			5'd22:   val = 32'sd57;
			5'd23:   val = 32'sd29;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== src/vector_rotate_2d_degrees.sv =====
// ----------------------------------------------------------------------------
// vector_rotate_2d_degrees
// Pipelined CORDIC that turns a Q8.8 vector counter-clockwise by an angle.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_tvalid/s_tready/s_tdata carry vec_x, vec_y and
//   turn_angle (1/64 degree, counter-clockwise positive). Output beats on
//   m_tvalid/m_tready/m_tdata carry rot_x and rot_y; m_tuser is the clipped
//   flag, set when either component saturated to the Q8.8 range.
//   The block holds no state between items: every input beat yields one
//   output beat, in order.
//   The pipeline has CORDIC_STAGES + 3 register stages (CORDIC stages capped
//   at 24): one for angle reduction and gain multiply, one for the half-turn
//   fold, one per CORDIC micro-rotation, one for rounding and saturation.
//   Throughput is one beat per cycle while m_tready stays high.
//   When the receiver stalls, the last result parks in a one-entry skid
//   register and the whole pipeline freezes; s_tready drops the cycle after
//   and returns as soon as the skid entry drains. Nothing is lost or repeated.
//   Reset clears all valid bits and the skid entry; s_tready is high after
//   reset.
// ----------------------------------------------------------------------------
module vector_rotate_2d_degrees
	import vrot_pkg::*;
#(
	parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES,
	parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH,
	localparam int IN_W  = ((2 * COMPONENT_WIDTH + ANGLE_W + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COMPONENT_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // vec_x, vec_y, turn_angle (low bits up), zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // rot_x, rot_y (low bits up), zero pad
	output logic             m_tuser    // clipped
);

	localparam int W      = COMPONENT_WIDTH;
	localparam int NS     = (CORDIC_STAGES > ATAN_TAB_SIZE) ? ATAN_TAB_SIZE : CORDIC_STAGES;
	localparam int PROD_W = W + GAIN_W;
	localparam int DW     = W + GUARD_BITS + 2;
	localparam logic signed [DW-1:0] RND_HALF = DW'(1) << (GUARD_BITS - 1);
	localparam logic signed [DW-1:0] SAT_HI = {{(DW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [DW-1:0] SAT_LO = {{(DW - W + 1){1'b1}}, {(W - 1){1'b0}}};
	localparam logic signed [W-1:0]  OUT_HI = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0]  OUT_LO = {1'b1, {(W - 1){1'b0}}};
	localparam logic signed [Z_W-1:0] Z_QUARTER = {QUARTER_TURN, {(Z_W - ANGLE_W){1'b0}}};

	// input field unpacking
	logic signed [W-1:0]       vec_x;
	logic signed [W-1:0]       vec_y;
	logic signed [ANGLE_W-1:0] turn_angle;

	assign vec_x      = s_tdata[W-1:0];
	assign vec_y      = s_tdata[2*W-1:W];
	assign turn_angle = s_tdata[2*W+ANGLE_W-1:2*W];

	// pipeline advance: frozen while the skid entry is occupied
	logic sk_valid_q;
	logic en;

	assign en       = !sk_valid_q;
	assign s_tready = !sk_valid_q;

	// ---------------- stage 1: angle reduction and gain multiply ----------------
	logic                      valid_s1;
	logic signed [ANGLE_W-1:0] ang_s1;
	logic signed [PROD_W-1:0]  px_s1;
	logic signed [PROD_W-1:0]  py_s1;
	logic signed [ANGLE_W-1:0] ang_red;

	// bring angle into [-180, 180)
	always_comb begin
		if (turn_angle >= HALF_TURN) begin
			ang_red = turn_angle - FULL_TURN;
		end else if (turn_angle < -HALF_TURN) begin
			ang_red = turn_angle + FULL_TURN;
		end else begin
			ang_red = turn_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang_red;
			px_s1  <= PROD_W'(vec_x) * PROD_W'(GAIN_Q24);
			py_s1  <= PROD_W'(vec_y) * PROD_W'(GAIN_Q24);
		end
	end

	// ---------------- stage 2: scale and half-turn fold ----------------
	// entry 0 of the CORDIC arrays is the stage 2 register
	logic [NS:0]           cv_s;
	logic signed [DW-1:0]  cx_s [0:NS];
	logic signed [DW-1:0]  cy_s [0:NS];
	logic signed [Z_W-1:0] cz_s [0:NS];
	logic signed [DW-1:0]  sx;
	logic signed [DW-1:0]  sy;
	logic signed [DW-1:0]  fx;
	logic signed [DW-1:0]  fy;
	logic signed [ANGLE_W-1:0] fang;

	// floor shift, then negate both components when the angle needs a half turn
	always_comb begin
		sx = DW'(px_s1 >>> GAIN_SHIFT);
		sy = DW'(py_s1 >>> GAIN_SHIFT);
		if (ang_s1 > QUARTER_TURN) begin
			fx   = -sx;
			fy   = -sy;
			fang = ang_s1 - HALF_TURN;
		end else if (ang_s1 < -QUARTER_TURN) begin
			fx   = -sx;
			fy   = -sy;
			fang = ang_s1 + HALF_TURN;
		end else begin
			fx   = sx;
			fy   = sy;
			fang = ang_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (en) begin
			cv_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= fx;
			cy_s[0] <= fy;
			cz_s[0] <= {fang, {(Z_W - ANGLE_W){1'b0}}};
		end
	end

	// ---------------- CORDIC micro-rotations, one register stage each ----------------
	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam logic [ATAN_IDX_W-1:0] IDX = ATAN_IDX_W'(i);
		localparam logic signed [Z_W-1:0] ATAN_I = atan_entry(IDX);

		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;

		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				if (cz_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - ATAN_I;
				end else begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + ATAN_I;
				end
			end
		end
	end

	// ---------------- last stage: round, saturate ----------------
	logic                 valid_sl;
	logic signed [W-1:0]  rx_sl;
	logic signed [W-1:0]  ry_sl;
	logic                 clip_sl;
	logic signed [DW-1:0] rnd_x;
	logic signed [DW-1:0] rnd_y;
	logic signed [W-1:0]  sat_x;
	logic signed [W-1:0]  sat_y;
	logic                 clip_x;
	logic                 clip_y;

	always_comb begin
		rnd_x = (cx_s[NS] + RND_HALF) >>> GUARD_BITS;
		rnd_y = (cy_s[NS] + RND_HALF) >>> GUARD_BITS;

		clip_x = 1'b1;
		if (rnd_x > SAT_HI) begin
			sat_x = OUT_HI;
		end else if (rnd_x < SAT_LO) begin
			sat_x = OUT_LO;
		end else begin
			sat_x  = rnd_x[W-1:0];
			clip_x = 1'b0;
		end

		clip_y = 1'b1;
		if (rnd_y > SAT_HI) begin
			sat_y = OUT_HI;
		end else if (rnd_y < SAT_LO) begin
			sat_y = OUT_LO;
		end else begin
			sat_y  = rnd_y[W-1:0];
			clip_y = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sl <= 1'b0;
		end else if (en) begin
			valid_sl <= cv_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_sl   <= sat_x;
			ry_sl   <= sat_y;
			clip_sl <= clip_x | clip_y;
		end
	end

	// ---------------- skid entry: park the last result when the receiver stalls ----------------
	logic signed [W-1:0] sk_x_q;
	logic signed [W-1:0] sk_y_q;
	logic                sk_clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (m_tready) begin
				sk_valid_q <= 1'b0;
			end
		end else if (valid_sl && !m_tready) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_valid_q && valid_sl && !m_tready) begin
			sk_x_q    <= rx_sl;
			sk_y_q    <= ry_sl;
			sk_clip_q <= clip_sl;
		end
	end

	// ---------------- output selection ----------------
	logic signed [W-1:0] out_x;
	logic signed [W-1:0] out_y;

	always_comb begin
		out_x   = sk_valid_q ? sk_x_q : rx_sl;
		out_y   = sk_valid_q ? sk_y_q : ry_sl;
		m_tuser = sk_valid_q ? sk_clip_q : clip_sl;
		m_tdata = '0;
		m_tdata[2*W-1:0] = {out_y, out_x};
	end

	assign m_tvalid = sk_valid_q | valid_sl;

	// ---------------- assertions ----------------
	// the folded angle handed to the CORDIC lies within a quarter turn
	assert property (@(posedge clk) disable iff (!arst_n)
		cv_s[0] |-> (cz_s[0] <= Z_QUARTER) && (cz_s[0] >= -Z_QUARTER))
		else $error("folded angle outside a quarter turn");

	// the reduced angle lies in [-180, 180)
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (ang_s1 >= -HALF_TURN) && (ang_s1 < HALF_TURN))
		else $error("reduced angle outside a half turn");

	// a clipped result sits on a range bound
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(out_x == OUT_HI) || (out_x == OUT_LO) || (out_y == OUT_HI) || (out_y == OUT_LO))
		else $error("clipped flag without a saturated component");

	// while the skid entry is full the last pipeline stage holds
	assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |=> (valid_sl == $past(valid_sl)) && $stable(rx_sl) && $stable(ry_sl))
		else $error("pipeline advanced during a stall");

	// the skid entry only loads while the last stage holds a result and the receiver stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_valid_q) |-> $past(valid_sl) && !$past(m_tready))
		else $error("skid entry loaded without a stalled result");

endmodule
